// ----- design/csrm_pkg.sv -----
// Shared types and constants for the capture slot ring manager.
// No dependencies; every other design file imports this package.

package csrm_pkg;

  // Default number of entries in each slot queue.
  localparam int CSRM_QUEUE_DEPTH = 4;

  // Field widths fixed by the stream format.
  localparam int SLOT_W  = 2;
  localparam int KIND_W  = 4;
  localparam int FLAG_W  = 16;
  localparam int TIME_W  = 64;
  localparam int SEQ_W   = 32;
  localparam int DEPTH_W = 3;
  localparam int WDOG_W  = 20;
  localparam int THR_W   = 3;
  localparam int CFG_IDX_W = 1;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 160;

  typedef enum logic [KIND_W-1:0] {
    KIND_XFER     = 4'd0,
    KIND_BEAT     = 4'd1,
    KIND_ALIGN    = 4'd2,
    KIND_REARM    = 4'd3,
    KIND_DMA_ERR  = 4'd4,
    KIND_LINK_ERR = 4'd5,
    KIND_WATCHDOG = 4'd6,
    KIND_DEQUEUE  = 4'd7,
    KIND_REQUEUE  = 4'd8,
    KIND_RELEASE  = 4'd9
  } kind_t;

  // Frame header flag bits.
  localparam logic [FLAG_W-1:0] FLAG_DROPPED    = 16'h0001;
  localparam logic [FLAG_W-1:0] FLAG_LATE       = 16'h0002;
  localparam logic [FLAG_W-1:0] FLAG_MISSING    = 16'h0004;
  localparam logic [FLAG_W-1:0] FLAG_ALIGN_LOST = 16'h0008;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_WDOG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LATE = 1'b1;
  localparam logic [WDOG_W-1:0]    WDOG_RESET = 20'd1500;
  localparam logic [THR_W-1:0]     LATE_RESET = 3'd2;

  // Slots held by the free queue and by the DMA registers after reset.
  localparam logic [SLOT_W-1:0] FREE_INIT_0 = 2'd2;
  localparam logic [SLOT_W-1:0] FREE_INIT_1 = 2'd3;
  localparam logic [SLOT_W-1:0] ACT_INIT_0  = 2'd0;
  localparam logic [SLOT_W-1:0] ACT_INIT_1  = 2'd1;

  // One operation on a slot queue.
  typedef struct packed {
    logic              pop;
    logic              push;
    logic              push_front;
    logic [SLOT_W-1:0] wdata;
  } q_cmd_t;

  // One input event.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] now_us;
    logic              current_target;
    logic [FLAG_W-1:0] error_flags;
    logic [SLOT_W-1:0] slot_in;
  } event_t;

  // One result.
  typedef struct packed {
    logic               ok;
    logic [SLOT_W-1:0]  out_slot;
    logic [SLOT_W-1:0]  install_slot;
    logic               rewrite_register;
    logic [SEQ_W-1:0]   hdr_seq;
    logic [SEQ_W-1:0]   heartbeat_count;
    logic               hdr_seq_lsb;
    logic [FLAG_W-1:0]  frame_flags;
    logic [TIME_W-1:0]  hdr_time_us;
    logic [DEPTH_W-1:0] tx_depth;
  } result_t;

endpackage

// ----- design/csrm_queue.sv -----
// Circular slot queue held in a small synchronous memory with a registered read port.
// Depends on csrm_pkg for the command type and the preload slot values.

module csrm_queue import csrm_pkg::*; #(
  parameter int QUEUE_DEPTH = CSRM_QUEUE_DEPTH,
  parameter bit PRELOAD     = 1'b0
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 rd_en,
  input  q_cmd_t                               cmd,
  output logic [SLOT_W-1:0]                    rd_data,
  output logic [$clog2(QUEUE_DEPTH + 1)-1:0]   count
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
  localparam logic [CNT_W-1:0] RESET_CNT = PRELOAD ? CNT_W'(2) : '0;

  logic [SLOT_W-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] raw_r;
  logic [PTR_W-1:0]  head_inc, head_dec, tail_idx;
  logic [SUM_W-1:0]  tail_sum, tail_wrap;

  always_comb begin
    tail_sum  = SUM_W'(head_r) + SUM_W'(cnt_r);
    tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? tail_sum - SUM_W'(QUEUE_DEPTH) : tail_sum;
    tail_idx  = tail_wrap[PTR_W-1:0];
    head_inc  = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
    head_dec  = (head_r == '0) ? PTR_W'(QUEUE_DEPTH - 1) : head_r - PTR_W'(1);
  end

  always_comb begin
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    priority if (cmd.pop) begin
      head_nxt = head_inc;
      cnt_nxt  = cnt_r - CNT_W'(1);
    end else if (cmd.push) begin
      cnt_nxt  = cnt_r + CNT_W'(1);
    end else if (cmd.push_front) begin
      head_nxt = head_dec;
      cnt_nxt  = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= RESET_CNT;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Memory array: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem_r[tail_idx] <= cmd.wdata;
    end else if (cmd.push_front) begin
      mem_r[head_dec] <= cmd.wdata;
    end
    if (rd_en) begin
      raw_r <= mem_r[head_r];
    end
  end

  assign count = cnt_r;

  generate
    if (PRELOAD) begin : g_preload
      // Entries never written read back as their reset contents.
      logic [QUEUE_DEPTH-1:0] vld_r;
      logic                   rvld_r;
      logic [PTR_W-1:0]       ridx_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r <= '0;
        end else if (cmd.push) begin
          vld_r[tail_idx] <= 1'b1;
        end else if (cmd.push_front) begin
          vld_r[head_dec] <= 1'b1;
        end
        if (rd_en) begin
          rvld_r <= vld_r[head_r];
          ridx_r <= head_r;
        end
      end

      always_comb begin
        if (rvld_r) begin
          rd_data = raw_r;
        end else if (ridx_r == '0) begin
          rd_data = FREE_INIT_0;
        end else if (ridx_r == PTR_W'(1)) begin
          rd_data = FREE_INIT_1;
        end else begin
          rd_data = '0;
        end
      end
    end else begin : g_plain
      assign rd_data = raw_r;
    end
  endgenerate

endmodule

// ----- design/csrm_ctrl.sv -----
// Event sequencer: captures an event, reads both queue heads, then updates state and the result.
// Depends on csrm_pkg; drives two csrm_queue instances through q_cmd_t commands.

module csrm_ctrl import csrm_pkg::*; #(
  parameter int QUEUE_DEPTH = CSRM_QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  event_t                             in_event,
  output logic                               out_valid,
  input  logic                               out_ready,
  output result_t                            out_result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [CFG_IDX_W-1:0]               cfg_index,
  input  logic [WDOG_W-1:0]                  cfg_data,
  output logic                               rd_en,
  output q_cmd_t                             free_cmd,
  input  logic [SLOT_W-1:0]                  free_rd,
  input  logic [$clog2(QUEUE_DEPTH + 1)-1:0] free_count,
  output q_cmd_t                             tx_cmd,
  input  logic [SLOT_W-1:0]                  tx_rd,
  input  logic [$clog2(QUEUE_DEPTH + 1)-1:0] tx_count
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t            state_r;
  logic              out_valid_r;
  event_t            ev_r;
  result_t           res_r, res_c;
  logic [SLOT_W-1:0] act_r [2];
  logic [SLOT_W-1:0] act_nxt [2];
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic [SEQ_W-1:0]  hb_r, hb_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic [FLAG_W-1:0] pend_r, pend_nxt;
  logic              aligned_r, aligned_nxt;
  logic [WDOG_W-1:0] wdog_r;
  logic [THR_W-1:0]  thr_r;

  logic              accept, fire;
  q_cmd_t            free_c, tx_c;
  logic              xfer_reg;
  logic [SLOT_W-1:0] done_slot, new_slot;
  logic [FLAG_W-1:0] hdr_flags;
  logic              free_any, free_room, tx_any, tx_room;
  logic [CNT_W-1:0]  tx_after;
  logic [CNT_W+DEPTH_W-1:0] depth_ext;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign fire      = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign rd_en     = accept;
  assign out_valid = out_valid_r;
  assign out_result = res_r;
  assign cfg_ready = 1'b1;
  assign free_cmd  = fire ? free_c : '0;
  assign tx_cmd    = fire ? tx_c : '0;

  always_comb begin
    free_any  = (free_count != '0);
    free_room = (free_count < CNT_W'(QUEUE_DEPTH));
    tx_any    = (tx_count != '0);
    tx_room   = (tx_count < CNT_W'(QUEUE_DEPTH));
    xfer_reg  = ~ev_r.current_target;
    done_slot = act_r[xfer_reg];
    hdr_flags = pend_r | ((CMP_W'(tx_count) >= CMP_W'(thr_r)) ? FLAG_LATE : '0);
    new_slot  = done_slot;

    act_nxt     = act_r;
    seq_nxt     = seq_r;
    hb_nxt      = hb_r;
    last_nxt    = last_r;
    pend_nxt    = pend_r;
    aligned_nxt = aligned_r;
    free_c      = '0;
    tx_c        = '0;
    res_c       = '0;

    unique case (ev_r.kind)
      KIND_XFER: begin
        pend_nxt = '0;
        res_c.out_slot = done_slot;
        res_c.rewrite_register = xfer_reg;
        if (!free_any) begin
          pend_nxt = FLAG_DROPPED;
        end else begin
          free_c.pop = 1'b1;
          res_c.hdr_seq         = seq_r;
          res_c.heartbeat_count = hb_r;
          res_c.hdr_seq_lsb     = seq_r[0];
          res_c.frame_flags     = hdr_flags;
          res_c.hdr_time_us     = ev_r.now_us;
          if (tx_room) begin
            tx_c.push  = 1'b1;
            tx_c.wdata = done_slot;
            res_c.ok   = 1'b1;
            new_slot   = free_rd;
          end else begin
            // The popped free slot is lost; the finished slot goes back in.
            pend_nxt = FLAG_DROPPED;
          end
        end
        res_c.install_slot = new_slot;
        act_nxt[xfer_reg]  = new_slot;
        seq_nxt            = seq_r + SEQ_W'(1);
      end
      KIND_BEAT: begin
        hb_nxt   = hb_r + SEQ_W'(1);
        last_nxt = ev_r.now_us;
      end
      KIND_ALIGN: begin
        aligned_nxt = 1'b1;
        seq_nxt     = '0;
        last_nxt    = ev_r.now_us;
      end
      KIND_REARM: begin
        act_nxt[0] = ACT_INIT_0;
        act_nxt[1] = ACT_INIT_1;
      end
      KIND_DMA_ERR: begin
        pend_nxt = pend_r | ev_r.error_flags | FLAG_ALIGN_LOST;
      end
      KIND_LINK_ERR: begin
        pend_nxt = pend_r | ev_r.error_flags;
      end
      KIND_WATCHDOG: begin
        if (aligned_r && ((ev_r.now_us - last_r) > TIME_W'(wdog_r))) begin
          pend_nxt = pend_r | FLAG_MISSING;
          last_nxt = ev_r.now_us;
        end
      end
      KIND_DEQUEUE: begin
        if (tx_any) begin
          tx_c.pop       = 1'b1;
          res_c.ok       = 1'b1;
          res_c.out_slot = tx_rd;
        end
      end
      KIND_REQUEUE: begin
        if (tx_room) begin
          tx_c.push_front = 1'b1;
          tx_c.wdata      = ev_r.slot_in;
        end else begin
          pend_nxt = pend_r | FLAG_DROPPED;
        end
      end
      KIND_RELEASE: begin
        if (free_room) begin
          free_c.push  = 1'b1;
          free_c.wdata = ev_r.slot_in;
        end else begin
          pend_nxt = pend_r | FLAG_DROPPED;
        end
      end
      default: begin
      end
    endcase

    tx_after = tx_count + CNT_W'(tx_c.push | tx_c.push_front) - CNT_W'(tx_c.pop);
    depth_ext = {{DEPTH_W{1'b0}}, tx_after};
    res_c.tx_depth = depth_ext[DEPTH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      act_r[0]    <= ACT_INIT_0;
      act_r[1]    <= ACT_INIT_1;
      seq_r       <= '0;
      hb_r        <= '0;
      last_r      <= '0;
      pend_r      <= '0;
      aligned_r   <= 1'b0;
      wdog_r      <= WDOG_RESET;
      thr_r       <= LATE_RESET;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (fire) begin
        out_valid_r <= 1'b1;
        act_r       <= act_nxt;
        seq_r       <= seq_nxt;
        hb_r        <= hb_nxt;
        last_r      <= last_nxt;
        pend_r      <= pend_nxt;
        aligned_r   <= aligned_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid) begin
        if (cfg_index == CFG_WDOG) begin
          wdog_r <= cfg_data;
        end else if (cfg_index == CFG_LATE) begin
          thr_r <= cfg_data[THR_W-1:0];
        end
      end
    end

    if (accept) begin
      ev_r <= in_event;
    end
    if (fire) begin
      res_r <= res_c;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (free_count <= CNT_W'(QUEUE_DEPTH)) && (tx_count <= CNT_W'(QUEUE_DEPTH)))
    else $error("slot queue count beyond its depth");

  a_tx_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    tx_cmd.pop |-> (tx_count != '0))
    else $error("transmit queue popped while empty");

  a_free_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    free_cmd.pop |-> (free_count != '0))
    else $error("free queue popped while empty");

  a_queue_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (ev_r.kind == KIND_XFER) && tx_cmd.push) |-> free_cmd.pop)
    else $error("frame queued without taking a free slot");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("executed event produced no result");

endmodule

// ----- design/capture_slot_ring_manager_top.sv -----
// Top level of the capture slot ring manager: stream ports, packing, and the slot queues.
// Depends on csrm_pkg, csrm_queue and csrm_ctrl.
//
//   Channel  Direction  Handshake            Payload
//   in_      slave      in_tvalid/in_tready  in_tdata (event fields), in_tuser (kind)
//   out_     master     out_tvalid/out_tready out_tdata (result fields)
//   cfg_     slave      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// In the accept cycle of a request both queue memories are read at their heads, and in the
// execute step that follows, the controller modifies state, writes the queue memories back
// and loads the result register, using the registered memory read data.
// Reset is synchronous and active low; no clearing pass is needed, because the free queue's
// reset contents come from per-entry valid bits and the transmit queue is guarded by its count.
// A stalled result holds the controller in its execute step; a new request is then accepted
// only once that result has moved into the output register. Configuration is always ready.

module capture_slot_ring_manager_top import csrm_pkg::*; #(
  parameter int QUEUE_DEPTH = CSRM_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [63:0] now_us, [64] current_target, [80:65] error_flags, [82:81] slot_in, [87:83] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [3:0] kind
  input  logic [KIND_W-1:0]      in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] ok, [2:1] out_slot, [4:3] install_slot, [5] rewrite_register, [37:6] hdr_seq,
  // [69:38] heartbeat_count, [70] hdr_seq_lsb, [86:71] frame_flags, [150:87] hdr_time_us,
  // [153:151] tx_depth, [159:154] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [WDOG_W-1:0]      cfg_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  event_t            in_event;
  result_t           result;
  logic              rd_en;
  q_cmd_t            free_cmd, tx_cmd;
  logic [SLOT_W-1:0] free_rd, tx_rd;
  logic [CNT_W-1:0]  free_count, tx_count;

  // Unpack the request; the kind travels on tuser.
  always_comb begin
    in_event.kind           = in_tuser;
    in_event.now_us         = in_tdata[63:0];
    in_event.current_target = in_tdata[64];
    in_event.error_flags    = in_tdata[80:65];
    in_event.slot_in        = in_tdata[82:81];
  end

  // Pack the result, first field in the lowest bits.
  assign out_tdata = {6'b000000, result.tx_depth, result.hdr_time_us, result.frame_flags,
                      result.hdr_seq_lsb, result.heartbeat_count, result.hdr_seq,
                      result.rewrite_register, result.install_slot, result.out_slot, result.ok};

  // Free slot queue, holding two spare slots after reset.
  csrm_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PRELOAD     (1'b1)
  ) u_free_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .cmd     (free_cmd),
    .rd_data (free_rd),
    .count   (free_count)
  );

  // Transmit queue of completed frames, empty after reset.
  csrm_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PRELOAD     (1'b0)
  ) u_tx_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .cmd     (tx_cmd),
    .rd_data (tx_rd),
    .count   (tx_count)
  );

  csrm_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_event   (in_event),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rd_en      (rd_en),
    .free_cmd   (free_cmd),
    .free_rd    (free_rd),
    .free_count (free_count),
    .tx_cmd     (tx_cmd),
    .tx_rd      (tx_rd),
    .tx_count   (tx_count)
  );

endmodule
